[rtl/packet_xor_checksum_codec_core_defines.svh]
// Assertion macros for the packet XOR checksum codec.
// Included by the top level; depends on nothing else.
`ifndef PACKET_XOR_CHECKSUM_CODEC_CORE_DEFINES_SVH
`define PACKET_XOR_CHECKSUM_CODEC_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PXC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PXC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pxc_pkg.sv]
// Shared types and constants for the packet XOR checksum codec.
// Used by packet_xor_checksum_codec_core; depends on nothing else.
package pxc_pkg;

  // Default width of the running byte counter.
  localparam int unsigned LENGTH_WIDTH_DEF = 16;

  // Configuration port geometry: three 32-bit registers at 4-byte spacing.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_PACKET_CODE   = 2'd0,
    REG_FIXED_KEY_ONE = 2'd1,
    REG_FIXED_KEY_TWO = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  // Request type codes.
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // One input request.
  typedef struct packed {
    logic        req_type;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        first_item;
    logic        last_item;
    logic [7:0]  key_byte;
    logic [7:0]  rx_checksum;
    logic [15:0] rx_length;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_has_byte;
    logic        packet_done;
    logic [7:0]  hdr_code;
    logic [15:0] hdr_length;
    logic [7:0]  hdr_key;
    logic [7:0]  hdr_checksum;
    logic        decode_ok;
  } out_item_t;

endpackage

[rtl/packet_xor_checksum_codec_core.sv]
// Packet XOR checksum codec: masks or unmasks up to one payload byte per request.
// Depends on pxc_pkg and packet_xor_checksum_codec_core_defines.svh.
//
// Usage:
// The input channel (in_valid, in_ready, in_data) carries up to one payload byte per
// request with first/last markers. The result channel (out_valid, out_ready,
// out_data) returns exactly one result per request, in order. Encode results
// carry the masked byte; the result of the last request also carries the
// header (code, length, masked key, masked checksum). Decode results carry the
// unmasked byte, and the last one carries the length and checksum verdict.
// The APB port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds the
// packet code and two fixed keys at byte addresses 0, 4 and 8; pready is
// always high. Write it only while no request is in flight.
// From acceptance, a request passes one input register, then the XOR and 8-bit
// sum logic into the result register. One request is taken per cycle while the
// result register drains, as the key, sum and count update with each request.
// When the receiver stalls, the result register holds and the input register
// still fills, so one further request is taken before in_ready drops.
// Synchronous reset clears the configuration registers, the packet state and both valid
// flags; no clearing pass is needed.
`include "packet_xor_checksum_codec_core_defines.svh"

module packet_xor_checksum_codec_core
  import pxc_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration registers
  logic [7:0] packet_code_r;
  logic [7:0] fixed_key_one_r;
  logic [7:0] fixed_key_two_r;

  // Packet state
  logic [7:0]              active_key_r,  active_key_nxt;
  logic [7:0]              byte_sum_r,    byte_sum_nxt;
  logic [LENGTH_WIDTH-1:0] byte_count_r,  byte_count_nxt;
  logic [7:0]              exp_cksum_r,   exp_cksum_nxt;
  logic [15:0]             exp_len_r,     exp_len_nxt;

  // Pipeline registers
  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  logic       s1_adv;
  logic       out_free;
  logic [7:0] fixed_key;
  logic [7:0] plain_byte;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;

  // APB register access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_code_r   <= '0;
      fixed_key_one_r <= '0;
      fixed_key_two_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PACKET_CODE:   packet_code_r   <= pwdata[7:0];
        REG_FIXED_KEY_ONE: fixed_key_one_r <= pwdata[7:0];
        REG_FIXED_KEY_TWO: fixed_key_two_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_PACKET_CODE:   prdata[7:0] = packet_code_r;
      REG_FIXED_KEY_ONE: prdata[7:0] = fixed_key_one_r;
      REG_FIXED_KEY_TWO: prdata[7:0] = fixed_key_two_r;
      default:           prdata      = '0;
    endcase
  end

  // Handshake: the result register drains or is empty, then stage one moves.
  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Per-byte masking, sum and count, plus the header or verdict on the last request.
  always_comb begin
    fixed_key      = fixed_key_one_r ^ fixed_key_two_r;
    active_key_nxt = active_key_r;
    byte_sum_nxt   = byte_sum_r;
    byte_count_nxt = byte_count_r;
    exp_cksum_nxt  = exp_cksum_r;
    exp_len_nxt    = exp_len_r;
    plain_byte     = '0;
    out_data_nxt   = '0;

    // The first request restarts the packet and loads the key.
    if (s1_data_r.first_item) begin
      byte_sum_nxt   = '0;
      byte_count_nxt = '0;
      if (s1_data_r.req_type == REQ_DECODE) begin
        active_key_nxt = s1_data_r.key_byte ^ fixed_key;
        exp_cksum_nxt  = s1_data_r.rx_checksum ^ s1_data_r.key_byte;
        exp_len_nxt    = s1_data_r.rx_length;
      end else begin
        active_key_nxt = s1_data_r.key_byte;
      end
    end

    if (s1_data_r.has_byte) begin
      out_data_nxt.out_byte = s1_data_r.data_byte ^ fixed_key ^ active_key_nxt;
      plain_byte = (s1_data_r.req_type == REQ_DECODE) ? out_data_nxt.out_byte
                                                      : s1_data_r.data_byte;
      byte_sum_nxt   = byte_sum_nxt + plain_byte;
      byte_count_nxt = byte_count_nxt + LENGTH_WIDTH'(1);
    end

    out_data_nxt.out_has_byte = s1_data_r.has_byte;
    out_data_nxt.packet_done  = s1_data_r.last_item;

    if (s1_data_r.last_item) begin
      if (s1_data_r.req_type == REQ_DECODE) begin
        out_data_nxt.decode_ok = (byte_count_nxt == LENGTH_WIDTH'(exp_len_nxt)) &&
                                 (byte_sum_nxt == exp_cksum_nxt);
      end else begin
        out_data_nxt.hdr_code     = packet_code_r;
        out_data_nxt.hdr_length   = 16'(byte_count_nxt);
        out_data_nxt.hdr_key      = active_key_nxt ^ fixed_key;
        out_data_nxt.hdr_checksum = byte_sum_nxt ^ active_key_nxt ^ fixed_key;
      end
    end
  end

  // Packet state updates as each request moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_key_r <= '0;
      byte_sum_r   <= '0;
      byte_count_r <= '0;
      exp_cksum_r  <= '0;
      exp_len_r    <= '0;
    end else if (s1_adv) begin
      active_key_r <= active_key_nxt;
      byte_sum_r   <= byte_sum_nxt;
      byte_count_r <= byte_count_nxt;
      exp_cksum_r  <= exp_cksum_nxt;
      exp_len_r    <= exp_len_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Assertions
  `PXC_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, s1_adv, out_valid_r,
    "request left stage one without reaching the result register")

  `PXC_ASSERT_NEXT(a_first_byte_count, clk, rst_n,
    s1_adv && s1_data_r.first_item && s1_data_r.has_byte,
    byte_count_r == LENGTH_WIDTH'(1),
    "byte count not one after a first request with payload")

  `PXC_ASSERT_NOW(a_idle_fields_zero, clk, rst_n,
    out_valid_r && !out_data_r.packet_done,
    !out_data_r.decode_ok && out_data_r.hdr_code == 8'd0 &&
    out_data_r.hdr_length == 16'd0,
    "header or verdict fields set on a result that ends no packet")

endmodule
